FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define BBPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbpd assertion failed");

// next-cycle implication under synchronous active-low reset
`define BBPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbpd assertion failed");

`endif

FILE: rtl/bbpd_pkg.sv
// shared widths, reset values, codes and controller/datapath bundles
// no dependencies; used by every other file of the block but assert_macros.svh
package bbpd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RATE_WIDTH = 20;
  localparam int ALPHA_FRAC = 16;
  localparam int GAIN_FRAC  = 16;

  localparam int DIST_W    = 13;
  localparam int SC_W      = 21;
  localparam int ALPHA_W   = 16;
  localparam int GAIN_W    = 24;
  localparam int TPS_W     = 10;
  localparam int SPR_W     = 16;
  localparam int TGT_W     = 13;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int POS_W      = DIST_W + FRAC_BITS + 1;
  localparam int ERR_W      = POS_W;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int EMA_PROD_W = ALPHA_W + 1 + POS_W;
  localparam int PP_W       = GAIN_W + 1 + ERR_W;
  localparam int PD_W       = GAIN_W + 1 + DIFF_W;
  localparam int PDS_W      = PD_W + 1;
  localparam int TS_W       = PDS_W - GAIN_FRAC;
  localparam int REM_FIX_W  = SC_W + FRAC_BITS;
  localparam int OFF_W      = ((TS_W > REM_FIX_W) ? TS_W : REM_FIX_W) + 1;
  localparam int OFF_LO_W   = 21;
  localparam int OFF_HI_W   = OFF_W - OFF_LO_W;
  localparam int PLO_W      = OFF_LO_W + TPS_W;
  localparam int PHI_W      = OFF_HI_W + TPS_W + 1;
  localparam int RP_W       = OFF_W + TPS_W + 1;
  localparam int RF_W       = RP_W - FRAC_BITS;

  localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd5898;
  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = 24'd2838;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = 24'd227011;
  localparam logic [TPS_W-1:0]   TPS_RST        = 10'd40;
  localparam logic [SPR_W-1:0]   SPR_RST        = 16'd1600;
  localparam logic [TGT_W-1:0]   TGT_LEFT_RST   = 13'd75;
  localparam logic [TGT_W-1:0]   TGT_CENTER_RST = 13'd125;
  localparam logic [TGT_W-1:0]   TGT_RIGHT_RST  = 13'd175;

  localparam logic [1:0] TGT_LEFT   = 2'd0;
  localparam logic [1:0] TGT_CENTER = 2'd1;
  localparam logic [1:0] TGT_RIGHT  = 2'd2;
  localparam logic [1:0] TGT_NONE   = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA,
    REG_GAIN_PROP,
    REG_GAIN_DERIV,
    REG_TICKS_PER_SEC,
    REG_STEPS_PER_REV,
    REG_TGT_LEFT,
    REG_TGT_CENTER,
    REG_TGT_RIGHT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_SELECT,
    KIND_LIMIT
  } item_kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PRIME,
    OP_EMA_MUL,
    OP_EMA_ADD,
    OP_ERR,
    OP_DIFF,
    OP_PD_MUL,
    OP_PD_SUM,
    OP_OFF,
    OP_RATE_MUL,
    OP_RATE_SUM,
    OP_SAT,
    OP_HALT,
    OP_SELECT,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       stopped;
    logic       primed;
    logic       rem_ready;
  } dp_stat_t;

endpackage

FILE: rtl/bbpd_in_if.sv
// input channel: valid/ready handshake with one item per beat
// depends on bbpd_pkg for field widths
interface bbpd_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [bbpd_pkg::DIST_W-1:0]       distance_mm;
  logic signed [bbpd_pkg::SC_W-1:0]  step_count;
  logic [1:0]                        target_choice;

  modport source (output valid, kind, distance_mm, step_count, target_choice, input ready);
  modport sink   (input valid, kind, distance_mm, step_count, target_choice, output ready);
endinterface

FILE: rtl/bbpd_out_if.sv
// result channel: valid/ready handshake with one result per beat
// depends on bbpd_pkg for field widths
interface bbpd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bbpd_pkg::RATE_WIDTH-1:0]  step_rate;
  logic                                    rate_valid;
  logic                                    rate_saturated;
  logic [1:0]                              selected_target;
  logic                                    halted;

  modport source (output valid, step_rate, rate_valid, rate_saturated, selected_target,
                  halted, input ready);
  modport sink   (input valid, step_rate, rate_valid, rate_saturated, selected_target,
                  halted, output ready);
endinterface

FILE: rtl/bbpd_rem.sv
// truncating remainder of the step count by steps per revolution
// restoring division, three bits per cycle; depends on bbpd_pkg
module bbpd_rem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [bbpd_pkg::SC_W-1:0]  dividend,
  input  logic [bbpd_pkg::SPR_W-1:0]        divisor,
  output logic                              ready,
  output logic signed [bbpd_pkg::SC_W-1:0]  rem
);

  localparam int STEP_BITS = 3;
  localparam int CYCLES    = (bbpd_pkg::SC_W + STEP_BITS - 1) / STEP_BITS;
  localparam int MAG_W     = CYCLES * STEP_BITS;
  localparam int CNT_W     = $clog2(CYCLES + 1);
  localparam int SPR_W     = bbpd_pkg::SPR_W;
  localparam int SC_W      = bbpd_pkg::SC_W;

  logic                    busy_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [MAG_W-1:0]        mag_r;
  logic [MAG_W-1:0]        mag_nxt;
  logic [SPR_W:0]          part_r;
  logic [SPR_W:0]          part_nxt;
  logic [SPR_W-1:0]        div_r;
  logic                    neg_r;
  logic                    zero_r;
  logic signed [SC_W-1:0]  sc_r;
  logic [SC_W-1:0]         abs_v;
  logic signed [SC_W-1:0]  rem_mag;

  // shift in dividend bits msb first, subtract where it fits
  always_comb begin
    part_nxt = part_r;
    mag_nxt  = mag_r;
    for (int i = 0; i < STEP_BITS; i++) begin
      part_nxt = {part_nxt[SPR_W-1:0], mag_nxt[MAG_W-1]};
      mag_nxt  = {mag_nxt[MAG_W-2:0], 1'b0};
      if (part_nxt >= {1'b0, div_r}) begin
        part_nxt = part_nxt - {1'b0, div_r};
      end
    end
  end

  assign abs_v = dividend[SC_W-1] ? (~dividend + 1'b1) : dividend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(CYCLES);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= MAG_W'(abs_v);
      part_r <= '0;
      div_r  <= divisor;
      neg_r  <= dividend[SC_W-1];
      zero_r <= (divisor == '0);
      sc_r   <= dividend;
    end else if (busy_r) begin
      mag_r  <= mag_nxt;
      part_r <= part_nxt;
    end
  end

  assign rem_mag = SC_W'(part_r[SPR_W-1:0]);
  assign rem     = zero_r ? sc_r : (neg_r ? -rem_mag : rem_mag);
  assign ready   = !busy_r;

endmodule

FILE: rtl/bbpd_dp.sv
// datapath: config registers, filter/pd state, staged multiplies, output register
// depends on bbpd_pkg and bbpd_rem; driven by bbpd_ctrl commands
module bbpd_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [bbpd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bbpd_pkg::CFG_W-1:0]              cfg_wdata,
  input  logic [1:0]                              in_kind,
  input  logic [bbpd_pkg::DIST_W-1:0]             in_distance_mm,
  input  logic signed [bbpd_pkg::SC_W-1:0]        in_step_count,
  input  logic [1:0]                              in_target_choice,
  input  bbpd_pkg::dp_cmd_t                       cmd,
  output bbpd_pkg::dp_stat_t                      stat,
  output logic signed [bbpd_pkg::RATE_WIDTH-1:0]  out_step_rate,
  output logic                                    out_rate_valid,
  output logic                                    out_rate_saturated,
  output logic [1:0]                              out_selected_target,
  output logic                                    out_halted
);

  localparam int F      = bbpd_pkg::FRAC_BITS;
  localparam int RW     = bbpd_pkg::RATE_WIDTH;
  localparam int POS_W  = bbpd_pkg::POS_W;
  localparam int DIFF_W = bbpd_pkg::DIFF_W;
  localparam int PDS_W  = bbpd_pkg::PDS_W;
  localparam int OFF_W  = bbpd_pkg::OFF_W;
  localparam int OLO_W  = bbpd_pkg::OFF_LO_W;
  localparam int RP_W   = bbpd_pkg::RP_W;
  localparam int RF_W   = bbpd_pkg::RF_W;
  localparam logic signed [RF_W-1:0] RF_MAX = {{(RF_W - RW + 1){1'b0}}, {(RW - 1){1'b1}}};
  localparam logic signed [RF_W-1:0] RF_MIN = ~RF_MAX;

  // config
  logic [bbpd_pkg::ALPHA_W-1:0] alpha_r;
  logic [bbpd_pkg::GAIN_W-1:0]  gp_r;
  logic [bbpd_pkg::GAIN_W-1:0]  gd_r;
  logic [bbpd_pkg::TPS_W-1:0]   tps_r;
  logic [bbpd_pkg::SPR_W-1:0]   spr_r;
  logic [bbpd_pkg::TGT_W-1:0]   tgt_left_r;
  logic [bbpd_pkg::TGT_W-1:0]   tgt_center_r;
  logic [bbpd_pkg::TGT_W-1:0]   tgt_right_r;

  // control state
  logic [1:0] sel_r;
  logic       primed_r;
  logic       stopped_r;

  // item and arithmetic
  logic [1:0]                           kind_r;
  logic [bbpd_pkg::DIST_W-1:0]          dist_r;
  logic [1:0]                           choice_r;
  logic signed [POS_W-1:0]              filt_r;
  logic signed [POS_W-1:0]              last_r;
  logic signed [POS_W-1:0]              err_r;
  logic signed [DIFF_W-1:0]             diff_r;
  logic signed [bbpd_pkg::EMA_PROD_W-1:0] ema_prod_r;
  logic signed [bbpd_pkg::PP_W-1:0]     pp_r;
  logic signed [bbpd_pkg::PD_W-1:0]     pd_r;
  logic signed [bbpd_pkg::TS_W-1:0]     ts_r;
  logic signed [OFF_W-1:0]              off_r;
  logic [bbpd_pkg::PLO_W-1:0]           plo_r;
  logic signed [bbpd_pkg::PHI_W-1:0]    phi_r;
  logic signed [RF_W-1:0]               rfull_r;
  logic signed [RW-1:0]                 rate_r;
  logic                                 sat_r;
  logic                                 vld_r;
  logic signed [RW-1:0]                 out_rate_r;
  logic                                 out_vld_r;
  logic                                 out_sat_r;
  logic [1:0]                           out_sel_r;
  logic                                 out_halt_r;

  logic [bbpd_pkg::TGT_W-1:0]           tgt_mm;
  logic signed [POS_W-1:0]              pos_fix;
  logic signed [POS_W-1:0]              tgt_fix;
  logic signed [POS_W-1:0]              ema_d;
  logic signed [DIFF_W-1:0]             diff_nxt;
  logic signed [PDS_W-1:0]              pd_sum;
  logic signed [bbpd_pkg::REM_FIX_W-1:0] rem_fix;
  logic signed [OFF_W-1:0]              off_nxt;
  logic signed [RP_W-1:0]               rate_prod;
  logic                                 rem_ready;
  logic signed [bbpd_pkg::SC_W-1:0]     rem_val;

  bbpd_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.capture),
    .dividend (in_step_count),
    .divisor  (spr_r),
    .ready    (rem_ready),
    .rem      (rem_val)
  );

  always_comb begin
    case (sel_r)
      bbpd_pkg::TGT_LEFT:  tgt_mm = tgt_left_r;
      bbpd_pkg::TGT_RIGHT: tgt_mm = tgt_right_r;
      default:             tgt_mm = tgt_center_r;
    endcase
  end

  assign pos_fix   = {1'b0, dist_r, {F{1'b0}}};
  assign tgt_fix   = {1'b0, tgt_mm, {F{1'b0}}};
  assign ema_d     = pos_fix - filt_r;
  assign diff_nxt  = DIFF_W'(err_r) - DIFF_W'(last_r);
  assign pd_sum    = PDS_W'(pp_r) + PDS_W'(pd_r);
  assign rem_fix   = {rem_val, {F{1'b0}}};
  assign off_nxt   = OFF_W'(ts_r) - OFF_W'(rem_fix);
  assign rate_prod = (RP_W'(phi_r) <<< OLO_W) + RP_W'(plo_r);

  // config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= bbpd_pkg::ALPHA_RST;
      gp_r         <= bbpd_pkg::GAIN_PROP_RST;
      gd_r         <= bbpd_pkg::GAIN_DERIV_RST;
      tps_r        <= bbpd_pkg::TPS_RST;
      spr_r        <= bbpd_pkg::SPR_RST;
      tgt_left_r   <= bbpd_pkg::TGT_LEFT_RST;
      tgt_center_r <= bbpd_pkg::TGT_CENTER_RST;
      tgt_right_r  <= bbpd_pkg::TGT_RIGHT_RST;
      sel_r        <= bbpd_pkg::TGT_CENTER;
      primed_r     <= 1'b0;
      stopped_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bbpd_pkg::REG_ALPHA:         alpha_r      <= cfg_wdata[bbpd_pkg::ALPHA_W-1:0];
          bbpd_pkg::REG_GAIN_PROP:     gp_r         <= cfg_wdata[bbpd_pkg::GAIN_W-1:0];
          bbpd_pkg::REG_GAIN_DERIV:    gd_r         <= cfg_wdata[bbpd_pkg::GAIN_W-1:0];
          bbpd_pkg::REG_TICKS_PER_SEC: tps_r        <= cfg_wdata[bbpd_pkg::TPS_W-1:0];
          bbpd_pkg::REG_STEPS_PER_REV: spr_r        <= cfg_wdata[bbpd_pkg::SPR_W-1:0];
          bbpd_pkg::REG_TGT_LEFT:      tgt_left_r   <= cfg_wdata[bbpd_pkg::TGT_W-1:0];
          bbpd_pkg::REG_TGT_CENTER:    tgt_center_r <= cfg_wdata[bbpd_pkg::TGT_W-1:0];
          bbpd_pkg::REG_TGT_RIGHT:     tgt_right_r  <= cfg_wdata[bbpd_pkg::TGT_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        bbpd_pkg::OP_PRIME:  primed_r <= 1'b1;
        bbpd_pkg::OP_HALT:   stopped_r <= 1'b1;
        bbpd_pkg::OP_SELECT: begin
          if (choice_r != bbpd_pkg::TGT_NONE) begin
            sel_r <= choice_r;
          end
        end
        default: ;
      endcase
    end
  end

  // item capture and staged arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      dist_r   <= in_distance_mm;
      choice_r <= in_target_choice;
    end
    case (cmd.op)
      bbpd_pkg::OP_PRIME: begin
        filt_r <= pos_fix;
        last_r <= tgt_fix - pos_fix;
      end
      bbpd_pkg::OP_EMA_MUL:  ema_prod_r <= $signed({1'b0, alpha_r}) * ema_d;
      bbpd_pkg::OP_EMA_ADD:  filt_r <= filt_r + ema_prod_r[bbpd_pkg::ALPHA_FRAC +: POS_W];
      bbpd_pkg::OP_ERR:      err_r <= tgt_fix - filt_r;
      bbpd_pkg::OP_DIFF: begin
        diff_r <= diff_nxt;
        last_r <= err_r;
      end
      bbpd_pkg::OP_PD_MUL: begin
        pp_r <= $signed({1'b0, gp_r}) * err_r;
        pd_r <= $signed({1'b0, gd_r}) * diff_r;
      end
      bbpd_pkg::OP_PD_SUM:   ts_r <= pd_sum[PDS_W-1:bbpd_pkg::GAIN_FRAC];
      bbpd_pkg::OP_OFF:      off_r <= off_nxt;
      bbpd_pkg::OP_RATE_MUL: begin
        plo_r <= off_r[OLO_W-1:0] * tps_r;
        phi_r <= $signed(off_r[OFF_W-1:OLO_W]) * $signed({1'b0, tps_r});
      end
      bbpd_pkg::OP_RATE_SUM: rfull_r <= rate_prod[RP_W-1:F];
      bbpd_pkg::OP_SAT: begin
        vld_r <= 1'b1;
        if (rfull_r > RF_MAX) begin
          rate_r <= RF_MAX[RW-1:0];
          sat_r  <= 1'b1;
        end else if (rfull_r < RF_MIN) begin
          rate_r <= RF_MIN[RW-1:0];
          sat_r  <= 1'b1;
        end else begin
          rate_r <= rfull_r[RW-1:0];
          sat_r  <= 1'b0;
        end
      end
      bbpd_pkg::OP_HALT, bbpd_pkg::OP_SELECT, bbpd_pkg::OP_CLEAR: begin
        rate_r <= '0;
        sat_r  <= 1'b0;
        vld_r  <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_rate_r <= rate_r;
      out_vld_r  <= vld_r;
      out_sat_r  <= sat_r;
      out_sel_r  <= sel_r;
      out_halt_r <= stopped_r;
    end
  end

  assign stat.kind      = kind_r;
  assign stat.stopped   = stopped_r;
  assign stat.primed    = primed_r;
  assign stat.rem_ready = rem_ready;

  assign out_step_rate       = out_rate_r;
  assign out_rate_valid      = out_vld_r;
  assign out_rate_saturated  = out_sat_r;
  assign out_selected_target = out_sel_r;
  assign out_halted          = out_halt_r;

endmodule

FILE: rtl/bbpd_ctrl.sv
// controller: sequences one item through the datapath and owns the handshakes
// depends on bbpd_pkg command and status bundles
module bbpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bbpd_pkg::dp_stat_t  stat,
  output bbpd_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EMA_MUL,
    S_EMA_ADD,
    S_ERR,
    S_DIFF,
    S_PD_MUL,
    S_PD_SUM,
    S_OFF,
    S_RATE_MUL,
    S_RATE_SUM,
    S_SAT,
    S_WRITE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.op       = bbpd_pkg::OP_NONE;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_WRITE;
        case (stat.kind)
          bbpd_pkg::KIND_LIMIT:  cmd.op = bbpd_pkg::OP_HALT;
          bbpd_pkg::KIND_SELECT: begin
            cmd.op = stat.stopped ? bbpd_pkg::OP_CLEAR : bbpd_pkg::OP_SELECT;
          end
          bbpd_pkg::KIND_TICK: begin
            if (stat.stopped) begin
              cmd.op = bbpd_pkg::OP_CLEAR;
            end else begin
              // first tick seeds filter and last error from its own sample
              if (!stat.primed) begin
                cmd.op = bbpd_pkg::OP_PRIME;
              end
              state_nxt = S_EMA_MUL;
            end
          end
          default: cmd.op = bbpd_pkg::OP_CLEAR;
        endcase
      end
      S_EMA_MUL: begin
        cmd.op    = bbpd_pkg::OP_EMA_MUL;
        state_nxt = S_EMA_ADD;
      end
      S_EMA_ADD: begin
        cmd.op    = bbpd_pkg::OP_EMA_ADD;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.op    = bbpd_pkg::OP_ERR;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = bbpd_pkg::OP_DIFF;
        state_nxt = S_PD_MUL;
      end
      S_PD_MUL: begin
        cmd.op    = bbpd_pkg::OP_PD_MUL;
        state_nxt = S_PD_SUM;
      end
      S_PD_SUM: begin
        cmd.op    = bbpd_pkg::OP_PD_SUM;
        state_nxt = S_OFF;
      end
      S_OFF: begin
        if (stat.rem_ready) begin
          cmd.op    = bbpd_pkg::OP_OFF;
          state_nxt = S_RATE_MUL;
        end
      end
      S_RATE_MUL: begin
        cmd.op    = bbpd_pkg::OP_RATE_MUL;
        state_nxt = S_RATE_SUM;
      end
      S_RATE_SUM: begin
        cmd.op    = bbpd_pkg::OP_RATE_SUM;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.op    = bbpd_pkg::OP_SAT;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/ball_beam_pd_step_rate_core.sv
// channel  dir  handshake     payload
// in_ch    in   valid/ready   kind, distance_mm, step_count, target_choice
// out_ch   out  valid/ready   step_rate, rate_valid, rate_saturated, selected_target, halted
// cfg_*    in   cfg_we        cfg_index, cfg_wdata (no read-back)
//
// control tick: from accept to result beat, one step of the sequencer per
//   multiply, add or clip stage; the remainder unit runs 3 bits per cycle alongside
// select, limit and halted items: decode, then straight to the result write
// one item in flight; the output register holds a beat while the next item is accepted
// synchronous active-low reset clears control state and reloads config defaults
// top level: depends on bbpd_pkg, bbpd_in_if, bbpd_out_if, bbpd_ctrl, bbpd_dp
module ball_beam_pd_step_rate_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbpd_pkg::CFG_W-1:0]      cfg_wdata,
  bbpd_in_if.sink                         in_ch,
  bbpd_out_if.source                      out_ch
);

  bbpd_pkg::dp_cmd_t  cmd;
  bbpd_pkg::dp_stat_t stat;

  bbpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbpd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_kind             (in_ch.kind),
    .in_distance_mm      (in_ch.distance_mm),
    .in_step_count       (in_ch.step_count),
    .in_target_choice    (in_ch.target_choice),
    .cmd                 (cmd),
    .stat                (stat),
    .out_step_rate       (out_ch.step_rate),
    .out_rate_valid      (out_ch.rate_valid),
    .out_rate_saturated  (out_ch.rate_saturated),
    .out_selected_target (out_ch.selected_target),
    .out_halted          (out_ch.halted)
  );

endmodule

FILE: rtl/bbpd_checker.sv
// port-level checks on the core, attached by bind
// depends on assert_macros.svh, bbpd_pkg and the channel interfaces
`include "assert_macros.svh"

module bbpd_checker (
  input logic         clk,
  input logic         rst_n,
  bbpd_in_if.sink     in_ch,
  bbpd_out_if.source  out_ch
);

  // a stalled result beat keeps its rate, rate-valid and halted fields
  `BBPD_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.step_rate) && $stable(out_ch.halted) && $stable(out_ch.rate_valid))

  // no rate unless it came from a tick
  `BBPD_ASSERT_IMP(a_idle_zero, clk, rst_n, out_ch.valid && !out_ch.rate_valid, out_ch.step_rate == '0 && !out_ch.rate_saturated)

  // a halted block never reports a rate
  `BBPD_ASSERT_IMP(a_halt_no_rate, clk, rst_n, out_ch.valid && out_ch.halted, !out_ch.rate_valid)

  // selection is always a real target
  `BBPD_ASSERT_IMP(a_sel_code, clk, rst_n, out_ch.valid, out_ch.selected_target == bbpd_pkg::TGT_LEFT || out_ch.selected_target == bbpd_pkg::TGT_CENTER || out_ch.selected_target == bbpd_pkg::TGT_RIGHT)

  // one item in flight: busy right after an accept
  `BBPD_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule

bind ball_beam_pd_step_rate_core bbpd_checker u_bbpd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
